[hw/rtl/spf_pkg.sv]
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the scanline polygon span filler
// Status codes, phases, state enums and the point key packing.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int SORT_CELLS_DEF = 16;
    localparam int XW             = 34;   // Q18.16 edge accumulator width
    localparam int KEY_W          = 32;

    typedef enum logic [2:0] {
        RS_OK     = 3'd0,
        RS_SPAN   = 3'd1,
        RS_NOSPAN = 3'd2,
        RS_FEW    = 3'd3,
        RS_ODD    = 3'd4,
        RS_OVF    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_COLLECT,
        PH_FULL,
        PH_SPANS,
        PH_ERR_FEW,
        PH_ERR_ODD,
        PH_ERR_OVF
    } phase_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_SETUP,
        E_DIV,
        E_SLOPE,
        E_STEP
    } edge_st_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_VFIN,
        ST_CLOSE,
        ST_CFIN,
        ST_SORT_INIT,
        ST_SORT_RD,
        ST_SORT_FLUSH,
        ST_SORT_DRAIN,
        ST_SORT_CHK,
        ST_SPAN_A,
        ST_SPAN_B,
        ST_DONE
    } top_st_t;

    typedef struct packed {
        logic              busy;
        logic              ovf;
        logic              pt_valid;
        logic [KEY_W-1:0]  pt_key;
    } edge_stat_t;

    function automatic logic [KEY_W-1:0] key_of(input logic [15:0] x, input logic [15:0] y);
        return {y ^ 16'h8000, x ^ 16'h8000};
    endfunction

endpackage

[hw/rtl/spf_ram.sv]
// ----------------------------------------------------------------------------
// spf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

[hw/rtl/spf_cell.sv]
// ----------------------------------------------------------------------------
// spf_cell: one cell of the systolic insertion sorter
// Keep the smaller of held and incoming value, pass the larger on; in drain
// mode take the held value of the next cell.
// ----------------------------------------------------------------------------
module spf_cell #(
    parameter int W = 42
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         drain,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    input  logic         nb_valid,
    input  logic [W-1:0] nb_data,
    output logic         held_valid,
    output logic [W-1:0] held_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);
    logic         hv_reg, hv_next;
    logic [W-1:0] hd_reg, hd_next;
    logic         ov_reg, ov_next;
    logic [W-1:0] od_reg, od_next;

    always_comb begin
        hv_next = hv_reg;
        hd_next = hd_reg;
        ov_next = 1'b0;
        od_next = od_reg;
        if (drain) begin
            hv_next = nb_valid;
            hd_next = nb_data;
        end else if (in_valid) begin
            if (!hv_reg) begin
                hv_next = 1'b1;
                hd_next = in_data;
            end else if (in_data < hd_reg) begin
                hd_next = in_data;
                ov_next = 1'b1;
                od_next = hd_reg;
            end else begin
                ov_next = 1'b1;
                od_next = in_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            hv_reg <= hv_next;
            ov_reg <= ov_next;
        end
        hd_reg <= hd_next;
        od_reg <= od_next;
    end

    assign held_valid = hv_reg;
    assign held_data  = hd_reg;
    assign out_valid  = ov_reg;
    assign out_data   = od_reg;
endmodule

[hw/rtl/spf_edge.sv]
// ----------------------------------------------------------------------------
// spf_edge: edge rasterizer
// Order endpoints, divide dx<<16 by dy one bit a cycle, then step one row a
// cycle and emit the rounded crossing key.
// ----------------------------------------------------------------------------
module spf_edge (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [15:0]    xa,
    input  logic signed [15:0]    ya,
    input  logic signed [15:0]    xb,
    input  logic signed [15:0]    yb,
    input  logic                  halt,
    output spf_pkg::edge_stat_t   stat
);
    import spf_pkg::*;

    edge_st_t st_reg, st_next;
    logic signed [15:0] xa_reg, xa_next, ya_reg, ya_next;
    logic signed [15:0] xb_reg, xb_next, yb_reg, yb_next;
    logic [15:0]        dy_reg, dy_next;
    logic [31:0]        num_reg, num_next;
    logic               neg_reg, neg_next;
    logic [15:0]        rem_reg, rem_next;
    logic [31:0]        q_reg, q_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [XW-1:0] m_reg, m_next, x_reg, x_next;
    logic signed [15:0] y_reg, y_next;

    logic               swap;
    logic signed [15:0] lx, ly, hx, hy;
    logic signed [16:0] dy_w, dx_w, adx;
    logic [16:0]        sh, diff;
    logic               ge;
    logic signed [XW-1:0] qe, xn, t, tn, vq;
    logic signed [15:0] yn;

    always_comb begin
        swap = ya_reg > yb_reg;
        lx   = swap ? xb_reg : xa_reg;
        ly   = swap ? yb_reg : ya_reg;
        hx   = swap ? xa_reg : xb_reg;
        hy   = swap ? ya_reg : yb_reg;
        dy_w = {hy[15], hy} - {ly[15], ly};
        dx_w = {hx[15], hx} - {lx[15], lx};
        adx  = dx_w[16] ? -dx_w : dx_w;
        sh   = {rem_reg, num_reg[31]};
        diff = sh - {1'b0, dy_reg};
        ge   = sh >= {1'b0, dy_reg};
        qe   = {2'b00, q_reg};
        xn   = x_reg + m_reg;
        t    = xn + XW'(32768);
        tn   = -t;
        vq   = t[XW-1] ? -(tn >>> 16) : (t >>> 16);
        yn   = y_reg + 16'sd1;
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            E_IDLE:  if (start) st_next = E_SETUP;
            E_SETUP: st_next = (ya_reg == yb_reg) ? E_IDLE : E_DIV;
            E_DIV:   if (cnt_reg == 5'd31) st_next = E_SLOPE;
            E_SLOPE: st_next = E_STEP;
            E_STEP:  if (halt || yn == yb_reg) st_next = E_IDLE;
            default: st_next = E_IDLE;
        endcase
    end

    always_comb begin
        xa_next  = xa_reg;
        ya_next  = ya_reg;
        xb_next  = xb_reg;
        yb_next  = yb_reg;
        dy_next  = dy_reg;
        num_next = num_reg;
        neg_next = neg_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        m_next   = m_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        case (st_reg)
            E_IDLE: begin
                if (start) begin
                    xa_next = xa;
                    ya_next = ya;
                    xb_next = xb;
                    yb_next = yb;
                end
            end
            E_SETUP: begin
                xa_next  = lx;
                ya_next  = ly;
                yb_next  = hy;
                dy_next  = dy_w[15:0];
                num_next = {adx[15:0], 16'h0000};
                neg_next = dx_w[16];
                rem_next = '0;
                q_next   = '0;
                cnt_next = '0;
            end
            E_DIV: begin
                rem_next = ge ? diff[15:0] : sh[15:0];
                q_next   = {q_reg[30:0], ge};
                num_next = {num_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
            end
            E_SLOPE: begin
                m_next = neg_reg ? -qe : qe;
                x_next = {{(XW-32){xa_reg[15]}}, xa_reg, 16'h0000};
                y_next = ya_reg;
            end
            E_STEP: begin
                x_next = xn;
                y_next = yn;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= E_IDLE;
        end else begin
            st_reg <= st_next;
        end
        xa_reg  <= xa_next;
        ya_reg  <= ya_next;
        xb_reg  <= xb_next;
        yb_reg  <= yb_next;
        dy_reg  <= dy_next;
        num_reg <= num_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        m_reg   <= m_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    always_comb begin
        stat.busy     = st_reg != E_IDLE;
        stat.ovf      = (st_reg == E_STEP) && halt;
        stat.pt_valid = (st_reg == E_STEP) && !halt;
        stat.pt_key   = key_of(vq[15:0], yn);
    end
endmodule

[hw/rtl/scanline_polygon_span_fill_top.sv]
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_top: even-odd scanline polygon span generator
// Input items (s_*): tuser = 0 adds the vertex in tdata, tlast marks the
// final vertex, which closes the polygon, checks and sorts the crossing
// points; tuser = 1 fetches the next span. Every input item yields exactly
// one result item on m_*, carrying a status and, for a valid span, its left
// x, right x, row and the fill color written on cfg_we/cfg_wdata.
// A vertex rasterizes its edge row by row; a span fetch steps over the
// stored points in order until two neighbours share a row. The final
// vertex adds the sort: ceil(n/SORT_CELLS) passes for n points, each
// streaming all n points from the single read port of the point RAM
// through the chain of sorting cells.
// One item is in work at a time; the next is taken as soon as its result
// has moved to the output register, even while that result still waits.
// When m_tready is low the result holds in the output register and a
// second finished result holds in the block until the first is taken.
// Reset (aresetn low, synchronous) empties the polygon, clears the color and
// drops any pending result; the point RAMs need no clearing.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill_top #(
    parameter int MAX_POINTS = spf_pkg::MAX_POINTS_DEF,
    parameter int SORT_CELLS = spf_pkg::SORT_CELLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,      // fill_color
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // vx[15:0], vy[31:16]
    input  logic        s_tuser,        // func
    input  logic        s_tlast,        // last_vertex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata         // status[2:0], span_x_start[18:3],
                                        // span_x_end[34:19], span_y[50:35],
                                        // span_color[58:51], zero[63:59]
);
    import spf_pkg::*;

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int CW      = AW + 1;
    localparam int KW      = KEY_W + AW;
    localparam int FLUSH_N = SORT_CELLS + 2;
    localparam int FW      = $clog2(FLUSH_N);
    localparam int DW      = $clog2(SORT_CELLS);

    top_st_t st_reg, st_next;
    phase_t  phase_reg, phase_next;
    logic [7:0]         color_reg, color_next;
    logic signed [15:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [15:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic               last_reg, last_next;
    logic [15:0]        vcount_reg, vcount_next;
    logic [CW-1:0]      pcount_reg, pcount_next;
    logic [CW-1:0]      sidx_reg, sidx_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [KEY_W-1:0]   a_reg, a_next;
    logic [CW-1:0]      rp_reg, rp_next;
    logic [CW-1:0]      op_reg, op_next;
    logic [KW-1:0]      thr_reg, thr_next;
    logic               thr_valid_reg, thr_valid_next;
    logic               fv_reg, fv_next;
    logic [AW-1:0]      fidx_reg, fidx_next;
    logic [FW-1:0]      fl_reg, fl_next;
    logic [DW-1:0]      dc_reg, dc_next;
    status_t            pst_reg, pst_next;
    logic [15:0]        pxs_reg, pxs_next, pxe_reg, pxe_next, py_reg, py_next;
    logic [7:0]         pcol_reg, pcol_next;
    logic               m_valid_reg, m_valid_next;
    logic [63:0]        m_data_reg, m_data_next;

    logic signed [15:0] in_x, in_y;
    logic               accept, ph_fresh, halt, drain, out_free;
    logic [15:0]        vc0;
    logic               edge_start;
    logic signed [15:0] e_xa, e_ya, e_xb, e_yb;
    edge_stat_t         estat;

    logic               a_we;
    logic [AW-1:0]      a_waddr, a_raddr;
    logic [KEY_W-1:0]   a_rdata;
    logic               b_we;
    logic [AW-1:0]      b_waddr, b_raddr;
    logic [KEY_W-1:0]   b_rdata;
    logic [KW-1:0]      feed;
    logic               feed_v;
    logic [CW-1:0]      i_inc;
    logic               span_hit, span_end, fetch_end;

    logic          c_in_v  [SORT_CELLS];
    logic [KW-1:0] c_in_d  [SORT_CELLS];
    logic          c_nb_v  [SORT_CELLS];
    logic [KW-1:0] c_nb_d  [SORT_CELLS];
    logic          c_hv    [SORT_CELLS];
    logic [KW-1:0] c_hd    [SORT_CELLS];
    logic          c_ov    [SORT_CELLS];
    logic [KW-1:0] c_od    [SORT_CELLS];

    assign in_x     = s_tdata[15:0];
    assign in_y     = s_tdata[31:16];
    assign s_tready = st_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign ph_fresh = (phase_reg != PH_COLLECT) && (phase_reg != PH_FULL);
    assign vc0      = ph_fresh ? 16'd0 : vcount_reg;
    assign halt     = pcount_reg >= CW'(MAX_POINTS);
    assign drain    = st_reg == ST_SORT_DRAIN;
    assign out_free = !m_valid_reg || m_tready;
    assign feed     = {a_rdata, fidx_reg};
    assign feed_v   = fv_reg && (!thr_valid_reg || feed > thr_reg);
    assign i_inc    = i_reg + CW'(1);
    assign span_hit = a_reg[31:16] == b_rdata[31:16];
    assign span_end = i_inc >= pcount_reg;
    assign fetch_end = (sidx_reg + CW'(1)) >= pcount_reg;

    spf_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (edge_start),
        .xa      (e_xa),
        .ya      (e_ya),
        .xb      (e_xb),
        .yb      (e_yb),
        .halt    (halt),
        .stat    (estat)
    );

    spf_ram #(.WIDTH(KEY_W), .DEPTH(MAX_POINTS)) u_raw_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (estat.pt_key),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    spf_ram #(.WIDTH(KEY_W), .DEPTH(MAX_POINTS)) u_sorted_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (c_hd[0][KW-1:AW]),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    genvar g;
    generate
        for (g = 0; g < SORT_CELLS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign c_in_v[g] = feed_v;
                assign c_in_d[g] = feed;
            end else begin : g_body
                assign c_in_v[g] = c_ov[g-1];
                assign c_in_d[g] = c_od[g-1];
            end
            if (g == SORT_CELLS - 1) begin : g_tail
                assign c_nb_v[g] = 1'b0;
                assign c_nb_d[g] = '0;
            end else begin : g_link
                assign c_nb_v[g] = c_hv[g+1];
                assign c_nb_d[g] = c_hd[g+1];
            end
            spf_cell #(.W(KW)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .drain      (drain),
                .in_valid   (c_in_v[g]),
                .in_data    (c_in_d[g]),
                .nb_valid   (c_nb_v[g]),
                .nb_data    (c_nb_d[g]),
                .held_valid (c_hv[g]),
                .held_data  (c_hd[g]),
                .out_valid  (c_ov[g]),
                .out_data   (c_od[g])
            );
        end
    endgenerate

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_tuser) begin
                        st_next = (vc0 != 16'd0) ? ST_EDGE : ST_VFIN;
                    end else if (phase_reg == PH_SPANS && !fetch_end) begin
                        st_next = ST_SPAN_A;
                    end else begin
                        st_next = ST_DONE;
                    end
                end
            end
            ST_EDGE:  if (!estat.busy) st_next = ST_VFIN;
            ST_VFIN: begin
                if (!last_reg || vcount_reg < 16'd3) st_next = ST_DONE;
                else st_next = ST_CLOSE;
            end
            ST_CLOSE: if (!estat.busy) st_next = ST_CFIN;
            ST_CFIN: begin
                if (phase_reg == PH_FULL || pcount_reg[0]) st_next = ST_DONE;
                else st_next = ST_SORT_INIT;
            end
            ST_SORT_INIT: st_next = (pcount_reg == '0) ? ST_DONE : ST_SORT_RD;
            ST_SORT_RD: if (rp_reg == pcount_reg - CW'(1)) st_next = ST_SORT_FLUSH;
            ST_SORT_FLUSH: if (fl_reg == FW'(FLUSH_N - 1)) st_next = ST_SORT_DRAIN;
            ST_SORT_DRAIN: if (dc_reg == DW'(SORT_CELLS - 1)) st_next = ST_SORT_CHK;
            ST_SORT_CHK: st_next = (op_reg == pcount_reg) ? ST_DONE : ST_SORT_RD;
            ST_SPAN_A: st_next = ST_SPAN_B;
            ST_SPAN_B: if (span_hit || span_end) st_next = ST_DONE;
            ST_DONE: if (out_free) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        color_next     = cfg_we ? cfg_wdata : color_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        last_next      = last_reg;
        vcount_next    = vcount_reg;
        pcount_next    = pcount_reg;
        sidx_next      = sidx_reg;
        i_next         = i_reg;
        a_next         = a_reg;
        rp_next        = rp_reg;
        op_next        = op_reg;
        thr_next       = thr_reg;
        thr_valid_next = thr_valid_reg;
        fv_next        = 1'b0;
        fidx_next      = rp_reg[AW-1:0];
        fl_next        = fl_reg;
        dc_next        = dc_reg;
        pst_next       = pst_reg;
        pxs_next       = '0;
        pxe_next       = '0;
        py_next        = '0;
        pcol_next      = '0;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        edge_start     = 1'b0;
        e_xa           = prev_x_reg;
        e_ya           = prev_y_reg;
        e_xb           = in_x;
        e_yb           = in_y;
        a_we           = estat.pt_valid;
        a_waddr        = pcount_reg[AW-1:0];
        a_raddr        = rp_reg[AW-1:0];
        b_we           = 1'b0;
        b_waddr        = op_reg[AW-1:0];
        b_raddr        = i_reg[AW-1:0];

        if (estat.pt_valid) begin
            pcount_next = pcount_reg + CW'(1);
        end
        if (estat.ovf) begin
            phase_next = PH_FULL;
        end

        case (st_reg)
            ST_IDLE: begin
                if (accept && !s_tuser) begin
                    if (ph_fresh) begin
                        phase_next  = PH_COLLECT;
                        pcount_next = '0;
                        sidx_next   = '0;
                    end
                    if (vc0 == 16'd0) begin
                        first_x_next = in_x;
                        first_y_next = in_y;
                    end else begin
                        edge_start = 1'b1;
                    end
                    prev_x_next = in_x;
                    prev_y_next = in_y;
                    last_next   = s_tlast;
                    vcount_next = (vc0 == 16'hFFFF) ? vc0 : vc0 + 16'd1;
                end else if (accept) begin
                    case (phase_reg)
                        PH_ERR_FEW: pst_next = RS_FEW;
                        PH_ERR_ODD: pst_next = RS_ODD;
                        PH_ERR_OVF: pst_next = RS_OVF;
                        PH_SPANS: begin
                            if (fetch_end) begin
                                sidx_next = pcount_reg;
                                pst_next  = RS_NOSPAN;
                            end else begin
                                b_raddr = sidx_reg[AW-1:0];
                                i_next  = sidx_reg + CW'(1);
                            end
                        end
                        default: pst_next = RS_NOSPAN;
                    endcase
                end
            end
            ST_VFIN: begin
                if (!last_reg) begin
                    pst_next = (phase_reg == PH_FULL) ? RS_OVF : RS_OK;
                end else if (vcount_reg < 16'd3) begin
                    phase_next = PH_ERR_FEW;
                    pst_next   = RS_FEW;
                end else begin
                    edge_start = 1'b1;
                    e_xa       = prev_x_reg;
                    e_ya       = prev_y_reg;
                    e_xb       = first_x_reg;
                    e_yb       = first_y_reg;
                end
            end
            ST_CFIN: begin
                if (phase_reg == PH_FULL) begin
                    phase_next = PH_ERR_OVF;
                    pst_next   = RS_OVF;
                end else if (pcount_reg[0]) begin
                    phase_next = PH_ERR_ODD;
                    pst_next   = RS_ODD;
                end
            end
            ST_SORT_INIT: begin
                rp_next        = '0;
                op_next        = '0;
                thr_valid_next = 1'b0;
                if (pcount_reg == '0) begin
                    phase_next = PH_SPANS;
                    sidx_next  = '0;
                    pst_next   = RS_OK;
                end
            end
            ST_SORT_RD: begin
                fv_next = 1'b1;
                rp_next = rp_reg + CW'(1);
                fl_next = '0;
            end
            ST_SORT_FLUSH: begin
                fl_next = fl_reg + FW'(1);
                dc_next = '0;
            end
            ST_SORT_DRAIN: begin
                if (c_hv[0]) begin
                    b_we           = 1'b1;
                    op_next        = op_reg + CW'(1);
                    thr_next       = c_hd[0];
                    thr_valid_next = 1'b1;
                end
                dc_next = dc_reg + DW'(1);
            end
            ST_SORT_CHK: begin
                rp_next = '0;
                if (op_reg == pcount_reg) begin
                    phase_next = PH_SPANS;
                    sidx_next  = '0;
                    pst_next   = RS_OK;
                end
            end
            ST_SPAN_A: begin
                a_next = b_rdata;
            end
            ST_SPAN_B: begin
                if (span_hit) begin
                    pst_next  = RS_SPAN;
                    pxs_next  = a_reg[15:0] ^ 16'h8000;
                    pxe_next  = b_rdata[15:0] ^ 16'h8000;
                    py_next   = b_rdata[31:16] ^ 16'h8000;
                    pcol_next = color_reg;
                    sidx_next = i_inc;
                end else begin
                    a_next  = b_rdata;
                    i_next  = i_inc;
                    b_raddr = i_inc[AW-1:0];
                    if (span_end) begin
                        sidx_next = pcount_reg;
                        pst_next  = RS_NOSPAN;
                    end
                end
            end
            ST_DONE: begin
                pxs_next  = pxs_reg;
                pxe_next  = pxe_reg;
                py_next   = py_reg;
                pcol_next = pcol_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b00000, pcol_reg, py_reg, pxe_reg, pxs_reg, pst_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_COLLECT;
            color_reg     <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            vcount_reg    <= '0;
            pcount_reg    <= '0;
            sidx_reg      <= '0;
            thr_valid_reg <= 1'b0;
            fv_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            color_reg     <= color_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            vcount_reg    <= vcount_next;
            pcount_reg    <= pcount_next;
            sidx_reg      <= sidx_next;
            thr_valid_reg <= thr_valid_next;
            fv_reg        <= fv_next;
            m_valid_reg   <= m_valid_next;
        end
        last_reg   <= last_next;
        i_reg      <= i_next;
        a_reg      <= a_next;
        rp_reg     <= rp_next;
        op_reg     <= op_next;
        thr_reg    <= thr_next;
        fidx_reg   <= fidx_next;
        fl_reg     <= fl_next;
        dc_reg     <= dc_next;
        pst_reg    <= pst_next;
        pxs_reg    <= pxs_next;
        pxe_reg    <= pxe_next;
        py_reg     <= py_next;
        pcol_reg   <= pcol_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
